// ----- sv/mbe_pkg.sv -----
package mbe_pkg;

    // request field widths
    localparam int ACTION_W = 2;
    localparam int OFFSET_W = 16;
    localparam int END_W    = 17;

    // fixed-point scale used by the reciprocal divider
    localparam int DIV_SHIFT = 24;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TEST  = 2'd0,
        ACT_SET   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_RANGE = 2'd3
    } action_e;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [OFFSET_W-1:0] first_bit;
        logic [END_W-1:0]    end_bit;
    } req_t;

    typedef struct packed {
        logic old_value;
        logic range_error;
    } res_t;

    // divider control from the sequencer
    typedef struct packed {
        logic load;  // capture operand and form quotient
        logic fix;   // form remainder from captured quotient
    } dm_ctrl_t;

endpackage

// ----- sv/mbe_divmod.sv -----
module mbe_divmod
    import mbe_pkg::*;
#(
    parameter int WORD_BITS = 64,
    parameter int QUOT_W    = 12,
    parameter int REM_W     = 6
)
(
    input  logic              clk,
    input  dm_ctrl_t          ctrl,
    input  logic [END_W-1:0]  x,
    output logic [QUOT_W-1:0] quot,
    output logic [REM_W-1:0]  rem
);

    // ceiling reciprocal is exact for 17-bit operands and divisors up to 64
    localparam longint RECIP  = ((64'd1 << DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int     RECIP_W = $clog2(RECIP + 1);
    localparam int     PROD_W  = (END_W + RECIP_W > DIV_SHIFT + QUOT_W)
                                 ? END_W + RECIP_W : DIV_SHIFT + QUOT_W;

    logic [PROD_W-1:0] prod;
    logic [END_W-1:0]  back;
    logic [END_W-1:0]  diff;
    logic [END_W-1:0]  x_reg;
    logic [QUOT_W-1:0] q_reg;
    logic [REM_W-1:0]  r_reg;

    assign prod = PROD_W'(x) * PROD_W'(RECIP);
    assign back = END_W'(q_reg) * END_W'(WORD_BITS);
    assign diff = x_reg - back;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            x_reg <= x;
            q_reg <= prod[DIV_SHIFT +: QUOT_W];
        end
        if (ctrl.fix)
        begin
            r_reg <= diff[REM_W-1:0];
        end
    end

    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

// ----- sv/mark_bitmap_engine_core.sv -----
// Word-organised mark bitmap of WORD_COUNT words of WORD_BITS bits, bit n held in
// word n / WORD_BITS at position n % WORD_BITS. Each request (test, test-and-set,
// test-and-clear, clear range) gives one result with the old bit value and a
// range-error flag; out-of-range requests change nothing. After reset the block
// sweeps all WORD_COUNT words of the store to zero, one word per cycle, and takes no
// request meanwhile. One request is worked on at a time by a small sequencer around
// a single reciprocal divider and a one-port-write, one-port-read word store:
// a single-bit request is divided, read and written; a clear range divides both
// offsets, writes each whole inner word and reads then writes each masked end word;
// an erroneous request or an empty range goes straight to the result. The result
// sits in an output register, so a new request is taken while it waits.
module mark_bitmap_engine_core
    import mbe_pkg::*;
#(
    parameter int WORD_BITS  = 64,
    parameter int WORD_COUNT = 1024
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    // address, position and quotient widths
    localparam int ADDR_W  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int REM_W   = $clog2(WORD_BITS);
    localparam int QUOT_W  = $clog2((1 << END_W) / WORD_BITS + 1);
    localparam int EXT_W   = (QUOT_W > ADDR_W) ? QUOT_W : ADDR_W;
    localparam int TOTAL_W = 24;
    localparam logic [TOTAL_W-1:0] TOTAL_BITS = TOTAL_W'(WORD_BITS * WORD_COUNT);
    localparam logic [ADDR_W-1:0]  LAST_WORD  = ADDR_W'(WORD_COUNT - 1);

    typedef enum logic [10:0] {
        ST_CLEAR     = 11'b000_0000_0001,
        ST_IDLE      = 11'b000_0000_0010,
        ST_DIVF      = 11'b000_0000_0100,
        ST_DIVE_Q    = 11'b000_0000_1000,
        ST_DIVE_R    = 11'b000_0001_0000,
        ST_RANGE_SET = 11'b000_0010_0000,
        ST_BIT_RD    = 11'b000_0100_0000,
        ST_BIT_WR    = 11'b000_1000_0000,
        ST_RNG_RD    = 11'b001_0000_0000,
        ST_RNG_WR    = 11'b010_0000_0000,
        ST_RESP      = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // word store
    logic [WORD_BITS-1:0] mem [WORD_COUNT];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata;

    // request context
    logic [ACTION_W-1:0] action_reg;
    logic [END_W-1:0]    end_reg;
    logic                err_reg;
    logic                old_reg, old_next;
    logic [ADDR_W-1:0]   cur_reg, cur_next;     // current word, also reset sweep counter
    logic [ADDR_W-1:0]   fw_reg;                // first word of a range
    logic [ADDR_W-1:0]   last_reg;              // last word touched by a range
    logic [REM_W-1:0]    fp_reg;                // bit position in first word
    logic [REM_W-1:0]    ep_reg;                // end position in last word

    logic res_valid_reg;
    res_t res_reg;

    // divider
    dm_ctrl_t          dm_ctrl;
    logic [END_W-1:0]  dm_x;
    logic [QUOT_W-1:0] dq;
    logic [REM_W-1:0]  dr;
    logic [EXT_W-1:0]  dq_ext;
    logic [EXT_W-1:0]  dq_dec;

    // request checks
    logic              accept;
    logic              req_is_range;
    logic              req_err;
    logic              req_empty;

    // range masking
    logic                 at_first;
    logic                 at_last;
    logic [REM_W-1:0]     lo_pos;
    logic [REM_W:0]       hi_pos;
    logic [WORD_BITS-1:0] clr_mask;
    logic [WORD_BITS-1:0] bit_word;

    mbe_divmod #(
        .WORD_BITS (WORD_BITS),
        .QUOT_W    (QUOT_W),
        .REM_W     (REM_W)
    ) u_divmod (
        .clk  (clk),
        .ctrl (dm_ctrl),
        .x    (dm_x),
        .quot (dq),
        .rem  (dr)
    );

    assign dq_ext = EXT_W'(dq);
    assign dq_dec = dq_ext - EXT_W'(1);

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;

    // bounds checks straight from the request
    assign req_is_range = (req.action == ACT_RANGE);
    assign req_empty    = (TOTAL_W'(req.first_bit) == TOTAL_W'(req.end_bit));
    always_comb
    begin
        if (req_is_range)
        begin
            req_err = (TOTAL_W'(req.end_bit) > TOTAL_BITS)
                      || (TOTAL_W'(req.first_bit) > TOTAL_W'(req.end_bit));
        end
        else
        begin
            req_err = (TOTAL_W'(req.first_bit) >= TOTAL_BITS);
        end
    end

    // bits to clear in the current word of a range
    assign at_first = (cur_reg == fw_reg);
    assign at_last  = (cur_reg == last_reg);
    assign lo_pos   = at_first ? fp_reg : '0;
    assign hi_pos   = (at_last && (ep_reg != '0)) ? {1'b0, ep_reg}
                                                  : (REM_W+1)'(WORD_BITS);
    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            clr_mask[i] = (REM_W'(i) >= lo_pos) && ((REM_W+1)'(i) < hi_pos);
        end
    end

    // single-bit update of the read word
    always_comb
    begin
        bit_word         = rd_data_reg;
        bit_word[fp_reg] = (action_reg == ACT_SET);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        old_next   = old_reg;
        dm_ctrl    = '0;
        dm_x       = {1'b0, req.first_bit};
        mem_we     = 1'b0;
        mem_wdata  = '0;
        mem_raddr  = cur_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // zero sweep after reset
                mem_we = 1'b1;
                if (cur_reg == LAST_WORD)
                begin
                    cur_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cur_next = cur_reg + ADDR_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    dm_ctrl.load = 1'b1;
                    old_next     = 1'b0;
                    if (req_err || (req_is_range && req_empty))
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_DIVF;
                    end
                end
            end
            ST_DIVF:
            begin
                dm_ctrl.fix = 1'b1;
                state_next  = (action_reg == ACT_RANGE) ? ST_DIVE_Q : ST_BIT_RD;
            end
            ST_DIVE_Q:
            begin
                // first word and position are ready, start on the end offset
                cur_next     = dq_ext[ADDR_W-1:0];
                dm_x         = end_reg;
                dm_ctrl.load = 1'b1;
                state_next   = ST_DIVE_R;
            end
            ST_DIVE_R:
            begin
                dm_ctrl.fix = 1'b1;
                state_next  = ST_RANGE_SET;
            end
            ST_RANGE_SET:
            begin
                state_next = ST_RNG_RD;
            end
            ST_BIT_RD:
            begin
                mem_raddr  = dq_ext[ADDR_W-1:0];
                cur_next   = dq_ext[ADDR_W-1:0];
                state_next = ST_BIT_WR;
            end
            ST_BIT_WR:
            begin
                old_next   = rd_data_reg[fp_reg];
                mem_we     = (action_reg != ACT_TEST);
                mem_wdata  = bit_word;
                state_next = ST_RESP;
            end
            ST_RNG_RD:
            begin
                if (at_first || at_last)
                begin
                    // partial word needs a read before the masked write
                    state_next = ST_RNG_WR;
                end
                else
                begin
                    mem_we   = 1'b1;
                    cur_next = cur_reg + ADDR_W'(1);
                end
            end
            ST_RNG_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = rd_data_reg & ~clr_mask;
                if (at_last)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    cur_next   = cur_reg + ADDR_W'(1);
                    state_next = ST_RNG_RD;
                end
            end
            ST_RESP:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // word store, read data registered
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cur_reg] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cur_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            if ((state_reg == ST_RESP) && (!res_valid_reg || res_ready))
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // request context and result payload
    always_ff @(posedge clk)
    begin
        old_reg <= old_next;
        if (accept)
        begin
            action_reg <= req.action;
            end_reg    <= req.end_bit;
            err_reg    <= req_err;
        end
        if (state_reg == ST_BIT_RD)
        begin
            fp_reg <= dr;
        end
        if (state_reg == ST_DIVE_Q)
        begin
            fw_reg <= dq_ext[ADDR_W-1:0];
            fp_reg <= dr;
        end
        if (state_reg == ST_RANGE_SET)
        begin
            // an end on a word boundary stops at the word before
            ep_reg   <= dr;
            last_reg <= (dr == '0) ? dq_dec[ADDR_W-1:0] : dq_ext[ADDR_W-1:0];
        end
        if ((state_reg == ST_RESP) && (!res_valid_reg || res_ready))
        begin
            res_reg.old_value   <= old_reg;
            res_reg.range_error <= err_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
